[rtl/core/ptd_pkg.sv]
`timescale 1ns / 1ps
package ptd_pkg;

  localparam int unsigned DivDw = 54;  // dividend width: 2*|num| + den
  localparam int unsigned DivVw = 26;  // divisor width: 2*den
  localparam int unsigned NumW  = 53;  // signed numerator width

  localparam logic [2:0] REG_SCALE_X      = 3'd0;
  localparam logic [2:0] REG_SCALE_Y      = 3'd1;
  localparam logic [2:0] REG_INIT_X       = 3'd2;
  localparam logic [2:0] REG_INIT_Y       = 3'd3;
  localparam logic [2:0] REG_INIT_HEADING = 3'd4;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CINIT, ST_CITER, ST_CFIN, ST_MMUL, ST_MACC, ST_OMUL, ST_OWR,
    ST_DNUM, ST_DM1, ST_DM2, ST_DSTART, ST_DWAIT, ST_DONE
  } state_e;

  function automatic logic [29:0] atan_fn(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0:  r = 30'h20000000;  5'd1:  r = 30'h12E4051E;
        5'd2:  r = 30'h09FB385B;  5'd3:  r = 30'h051111D4;
        5'd4:  r = 30'h028B0D43;  5'd5:  r = 30'h0145D7E1;
        5'd6:  r = 30'h00A2F61E;  5'd7:  r = 30'h00517C55;
        5'd8:  r = 30'h0028BE53;  5'd9:  r = 30'h00145F2F;
        5'd10: r = 30'h000A2F98;  5'd11: r = 30'h000517CC;
        5'd12: r = 30'h00028BE6;  5'd13: r = 30'h000145F3;
        5'd14: r = 30'h0000A2FA;  5'd15: r = 30'h0000517D;
        5'd16: r = 30'h000028BE;  5'd17: r = 30'h0000145F;
        5'd18: r = 30'h00000A30;  5'd19: r = 30'h00000518;
        5'd20: r = 30'h0000028C;  5'd21: r = 30'h00000146;
        5'd22: r = 30'h000000A3;  5'd23: r = 30'h00000051;
        default: r = 30'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [55:0] v);
    logic [31:0] r;
    begin
      if (v > 56'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -56'sh8000_0000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

[rtl/core/ptd_div.sv]
`timescale 1ns / 1ps
module ptd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptd_pkg::DivDw-1:0]     num_i,
  input  logic [ptd_pkg::DivVw-1:0]     den_i,
  output logic [ptd_pkg::DivDw-1:0]     quo_o,
  output logic                          done_o
);
  localparam int unsigned Dw = ptd_pkg::DivDw;
  localparam int unsigned Vw = ptd_pkg::DivVw;

  logic [Dw-1:0] dvd_q, dvd_d;
  logic [Vw-1:0] rem_q, rem_d, den_q;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q;
  logic [Vw:0]   rem_sh;
  logic          take_bit;

  always_comb begin
    rem_sh   = {rem_q, dvd_q[Dw-1]};
    take_bit = rem_sh >= {1'b0, den_q};
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    if (start_i) begin
      dvd_d  = num_i;
      rem_d  = '0;
      cnt_d  = 7'(Dw);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take_bit ? Vw'(rem_sh - {1'b0, den_q}) : rem_sh[Vw-1:0];
      dvd_d = {dvd_q[Dw-2:0], take_bit};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  assign quo_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= busy_q && (cnt_q == 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
endmodule

[rtl/core/pose_transform_2d.sv]
`timescale 1ns / 1ps
// Channel     Dir  Handshake               Payload
// s_axis      in   s_axis_tvalid/tready    forward, lateral, turn
// m_axis      out  m_axis_tvalid/tready    to_* and from_* matrices (12 x 32 bit)
// cfg         in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One transaction uses two CORDIC passes on one shift-add unit, one shared 33x19
// multiplier and a one-bit-per-cycle divider run six times. Reset loads the register
// reset values into the pose. The result sits in an output register, so the next input
// is taken while it waits; a new result waits only if the old one is not taken yet.
module pose_transform_2d #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // forward[31:0], lateral[63:32], turn[79:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // to_m00, to_m01, to_m10, to_m11, to_tx, to_ty,
  // from_m00, from_m10, from_m01, from_m11, from_tx, from_ty (32 bit each, low first)
  output logic [383:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  localparam int unsigned Steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int unsigned Nw    = ptd_pkg::NumW;
  localparam int unsigned Dw    = ptd_pkg::DivDw;

  ptd_pkg::state_e state_q, state_d;

  logic [15:0] scale_x_q, scale_y_q;
  logic [31:0] pos_x_q, pos_y_q;
  logic [15:0] heading_q;
  logic [31:0] fwd_q, lat_q;
  logic [15:0] turn_q;
  logic        phase_q, flip_q;
  logic [4:0]  cnt_q;
  logic [3:0]  idx_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [17:0] c_q, s_q;
  logic signed [51:0] prod_q, acc_q;
  logic signed [Nw-1:0] num_q;
  logic [31:0] res_q [12];
  logic [383:0] out_q;
  logic        mv_q;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] mul_p;

  always_comb begin
    mul_a = {fwd_q[31], fwd_q};
    mul_b = {c_q[17], c_q};
    case (state_q)
      ptd_pkg::ST_MMUL: begin
        mul_a = (idx_q < 4'd2) ? {fwd_q[31], fwd_q} : {lat_q[31], lat_q};
        mul_b = (idx_q == 4'd0 || idx_q == 4'd3) ? {c_q[17], c_q} : {s_q[17], s_q};
      end
      ptd_pkg::ST_OMUL: begin
        mul_a = (idx_q < 4'd2) ? {17'd0, scale_x_q} : {17'd0, scale_y_q};
        mul_b = (idx_q == 4'd0 || idx_q == 4'd3) ? {c_q[17], c_q} : {s_q[17], s_q};
      end
      ptd_pkg::ST_DNUM: begin
        mul_a = {pos_x_q[31], pos_x_q};
        mul_b = (idx_q == 4'd10) ? {c_q[17], c_q} : {s_q[17], s_q};
      end
      ptd_pkg::ST_DM1: begin
        mul_a = {pos_y_q[31], pos_y_q};
        mul_b = (idx_q == 4'd10) ? {s_q[17], s_q} : {c_q[17], c_q};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // CORDIC step
  logic signed [33:0] xs, ys, at;
  logic [31:0] ang;
  logic        flip_w;
  logic signed [33:0] xf, yf;
  logic signed [33:0] cr, sr;
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign at     = {4'd0, ptd_pkg::atan_fn(cnt_q)};
  assign ang    = {heading_q, 16'h0};
  assign flip_w = ang[31] ^ ang[30];
  assign xf     = flip_q ? -x_q : x_q;
  assign yf     = flip_q ? -y_q : y_q;
  assign cr     = (xf + 34'sd8192) >>> 14;
  assign sr     = (yf + 34'sd8192) >>> 14;

  // position update
  logic signed [35:0] rnd16;
  logic signed [55:0] pos_sum;
  logic signed [55:0] posx_ext, posy_ext;
  assign rnd16    = 36'((prod_q + 52'sd32768) >>> 16);
  assign posx_ext = {{24{pos_x_q[31]}}, pos_x_q};
  assign posy_ext = {{24{pos_y_q[31]}}, pos_y_q};
  always_comb begin
    case (idx_q)
      4'd0:    pos_sum = posx_ext + 56'(rnd16);
      4'd1:    pos_sum = posy_ext + 56'(rnd16);
      4'd2:    pos_sum = posx_ext - 56'(rnd16);
      default: pos_sum = posy_ext + 56'(rnd16);
    endcase
  end

  // scaled product: round half up by 2^8
  logic signed [51:0] pneg;
  logic signed [55:0] prnd;
  assign pneg = (idx_q == 4'd2) ? -prod_q : prod_q;
  assign prnd = 56'((pneg + 52'sd128) >>> 8);

  // division operands
  logic [24:0] den;
  logic [Nw-1:0] mag;
  logic [Dw-1:0] div_num;
  logic [Dw-1:0] div_quo;
  logic          div_start, div_done;
  logic signed [Nw-1:0] c_sh, s_sh, num_sel;
  logic [15:0] dx, dy;
  assign dx = (scale_x_q == 16'd0) ? 16'd1 : scale_x_q;
  assign dy = (scale_y_q == 16'd0) ? 16'd1 : scale_y_q;
  always_comb begin
    case (idx_q)
      4'd6, 4'd7: den = {9'd0, dx};
      4'd8, 4'd9: den = {9'd0, dy};
      4'd10:      den = {1'b0, dx, 8'd0};
      default:    den = {1'b0, dy, 8'd0};
    endcase
  end
  assign mag     = num_q[Nw-1] ? Nw'(-num_q) : num_q;
  assign div_num = {mag, 1'b0} + {29'd0, den};
  assign c_sh    = {{(Nw-26){c_q[17]}}, c_q, 8'd0};
  assign s_sh    = {{(Nw-26){s_q[17]}}, s_q, 8'd0};
  always_comb begin
    case (idx_q)
      4'd6:    num_sel = c_sh;
      4'd7:    num_sel = s_sh;
      4'd8:    num_sel = -s_sh;
      default: num_sel = c_sh;
    endcase
  end

  logic [31:0] div_res;
  always_comb begin
    if (num_q[Nw-1]) begin
      div_res = (div_quo > Dw'(33'h8000_0000)) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
    end else begin
      div_res = (div_quo > Dw'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  ptd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({den, 1'b0}),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  logic s_acc, m_acc, out_load;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ptd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ptd_pkg::ST_CINIT;
      end
      ptd_pkg::ST_CINIT: state_d = ptd_pkg::ST_CITER;
      ptd_pkg::ST_CITER: begin
        if (cnt_q == 5'(Steps - 1)) state_d = ptd_pkg::ST_CFIN;
      end
      ptd_pkg::ST_CFIN: state_d = phase_q ? ptd_pkg::ST_OMUL : ptd_pkg::ST_MMUL;
      ptd_pkg::ST_MMUL: state_d = ptd_pkg::ST_MACC;
      ptd_pkg::ST_MACC: state_d = (idx_q == 4'd3) ? ptd_pkg::ST_CINIT : ptd_pkg::ST_MMUL;
      ptd_pkg::ST_OMUL: state_d = ptd_pkg::ST_OWR;
      ptd_pkg::ST_OWR:  state_d = (idx_q == 4'd3) ? ptd_pkg::ST_DNUM : ptd_pkg::ST_OMUL;
      ptd_pkg::ST_DNUM: state_d = (idx_q < 4'd10) ? ptd_pkg::ST_DSTART : ptd_pkg::ST_DM1;
      ptd_pkg::ST_DM1:  state_d = ptd_pkg::ST_DM2;
      ptd_pkg::ST_DM2:  state_d = ptd_pkg::ST_DSTART;
      ptd_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ptd_pkg::ST_DWAIT;
      end
      ptd_pkg::ST_DWAIT: begin
        if (div_done) state_d = (idx_q == 4'd11) ? ptd_pkg::ST_DONE : ptd_pkg::ST_DNUM;
      end
      ptd_pkg::ST_DONE: begin
        if (!mv_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ptd_pkg::ST_IDLE;
        end
      end
      default: state_d = ptd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptd_pkg::ST_IDLE;
      mv_q      <= 1'b0;
      scale_x_q <= 16'd256;
      scale_y_q <= 16'd256;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      heading_q <= '0;
      phase_q   <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) mv_q <= 1'b1;
      else if (m_acc) mv_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ptd_pkg::REG_SCALE_X:      scale_x_q <= cfg_wdata_i[15:0];
          ptd_pkg::REG_SCALE_Y:      scale_y_q <= cfg_wdata_i[15:0];
          ptd_pkg::REG_INIT_X:       pos_x_q   <= cfg_wdata_i;
          ptd_pkg::REG_INIT_Y:       pos_y_q   <= cfg_wdata_i;
          ptd_pkg::REG_INIT_HEADING: heading_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        ptd_pkg::ST_IDLE: if (s_acc) phase_q <= 1'b0;
        ptd_pkg::ST_CINIT: cnt_q <= '0;
        ptd_pkg::ST_CITER: cnt_q <= cnt_q + 5'd1;
        ptd_pkg::ST_CFIN:  idx_q <= '0;
        ptd_pkg::ST_MACC: begin
          if (idx_q[0]) pos_y_q <= ptd_pkg::sat32(pos_sum);
          else          pos_x_q <= ptd_pkg::sat32(pos_sum);
          if (idx_q == 4'd3) begin
            heading_q <= heading_q + turn_q;
            phase_q   <= 1'b1;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        ptd_pkg::ST_OWR: idx_q <= (idx_q == 4'd3) ? 4'd6 : idx_q + 4'd1;
        ptd_pkg::ST_DWAIT: if (div_done) idx_q <= idx_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (s_acc) begin
          fwd_q  <= s_axis_tdata[31:0];
          lat_q  <= s_axis_tdata[63:32];
          turn_q <= s_axis_tdata[79:64];
        end
      end
      ptd_pkg::ST_CINIT: begin
        x_q    <= ptd_pkg::CordicGain;
        y_q    <= '0;
        z_q    <= {{2{ang[31] ^ flip_w}}, ang[31] ^ flip_w, ang[30:0]};
        flip_q <= flip_w;
      end
      ptd_pkg::ST_CITER: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      ptd_pkg::ST_CFIN: begin
        c_q <= cr[17:0];
        s_q <= sr[17:0];
      end
      ptd_pkg::ST_MMUL, ptd_pkg::ST_OMUL, ptd_pkg::ST_DNUM: begin
        prod_q <= mul_p;
        if (state_q == ptd_pkg::ST_DNUM && idx_q < 4'd10) num_q <= num_sel;
      end
      ptd_pkg::ST_OWR: res_q[idx_q] <= ptd_pkg::sat32(prnd);
      ptd_pkg::ST_DM1: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ptd_pkg::ST_DM2: begin
        if (idx_q == 4'd10) num_q <= Nw'(-(acc_q + prod_q));
        else                num_q <= Nw'(acc_q - prod_q);
      end
      ptd_pkg::ST_DWAIT: if (div_done) res_q[idx_q] <= div_res;
      default: ;
    endcase
    if (out_load) begin
      out_q <= {res_q[11], res_q[10], res_q[9], res_q[8], res_q[7], res_q[6],
                pos_y_q, pos_x_q, res_q[3], res_q[2], res_q[1], res_q[0]};
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = out_q;
endmodule

[tb/sv/pose_transform_2d_test.sv]
`timescale 1ns / 1ps
module pose_transform_2d_test;

  localparam int unsigned Steps = 16;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 600;

  typedef struct packed {
    logic [15:0] turn;
    logic [31:0] lateral;
    logic [31:0] forward;
  } move_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;   // forward, lateral, turn
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [383:0] m_axis_tdata;        // to_m00..to_ty, from_m00..from_ty, low first
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_wdata_i = '0;

  pose_transform_2d #(.CORDIC_STEPS(Steps)) uut (.*);

  always #5 clk_i = ~clk_i;

  // predicted pose and registers
  longint       px, py;
  logic [15:0]  hdg;
  longint       sc_x, sc_y;

  logic [383:0] matrix_q[$];
  int           errors = 0;
  int unsigned  cycles = 0;
  bit           hold_off = 1'b0;
  int unsigned  gap_max = 4;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx32(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint qdiv(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return sat(num < 0 ? -q : q);
  endfunction

  task automatic cordic(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, xs, ys;
    logic [29:0] at [0:23];
    at = '{30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
           30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
           30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
           30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
           30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051};
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = sx32(a);
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(at[i]);
      end else begin
        x += ys; y -= xs; z += longint'(at[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
  endtask

  task automatic predict_matrices(input move_t m);
    longint c, s, f, l, dx, dy;
    longint r[12];
    logic [383:0] w;
    f = sx32(m.forward);
    l = sx32(m.lateral);
    cordic(hdg, c, s);
    px = sat(px + ((f * c + 32768) >>> 16));
    py = sat(py + ((f * s + 32768) >>> 16));
    px = sat(px - ((l * s + 32768) >>> 16));
    py = sat(py + ((l * c + 32768) >>> 16));
    hdg = hdg + m.turn;
    cordic(hdg, c, s);
    dx = sc_x != 0 ? sc_x : 1;
    dy = sc_y != 0 ? sc_y : 1;
    r[0] = sat((sc_x * c + 128) >>> 8);
    r[1] = sat((sc_x * s + 128) >>> 8);
    r[2] = sat((-(sc_y * s) + 128) >>> 8);
    r[3] = sat((sc_y * c + 128) >>> 8);
    r[4] = px;
    r[5] = py;
    r[6] = qdiv(c * 256, dx);
    r[7] = qdiv(s * 256, dx);
    r[8] = qdiv(-s * 256, dy);
    r[9] = qdiv(c * 256, dy);
    r[10] = qdiv(-(px * c + py * s), 256 * dx);
    r[11] = qdiv(px * s - py * c, 256 * dy);
    for (int k = 0; k < 12; k++) w[32*k +: 32] = r[k][31:0];
    matrix_q.push_back(w);
  endtask

  // result checker and stall pattern
  always @(posedge clk_i) begin
    logic [383:0] exp_w;
    string fname [0:11];
    fname = '{"to_m00", "to_m01", "to_m10", "to_m11", "to_tx", "to_ty",
              "from_m00", "from_m10", "from_m01", "from_m11", "from_tx", "from_ty"};
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_w = matrix_q.pop_front();
        for (int k = 0; k < 12; k++)
          if (m_axis_tdata[32*k +: 32] !== exp_w[32*k +: 32]) begin
            $error("%s: expected %h, got %h", fname[k], exp_w[32*k +: 32],
                   m_axis_tdata[32*k +: 32]);
            errors++;
          end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if ((cycles / 3000) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // tvalid stays high into the next transaction of a burst; a gap or wait_idle drops it
  task automatic send_move(input move_t m);
    if (gap_max > 0 && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
    end
    s_axis_tdata <= m;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_matrices(m);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ptd_pkg::REG_SCALE_X:      sc_x = val[15:0];
      ptd_pkg::REG_SCALE_Y:      sc_y = val[15:0];
      ptd_pkg::REG_INIT_X:       px = sx32(val);
      ptd_pkg::REG_INIT_Y:       py = sx32(val);
      ptd_pkg::REG_INIT_HEADING: hdg = val[15:0];
      default: ;
    endcase
  endtask

  function automatic move_t rand_move();
    move_t m;
    m.forward = $urandom();
    m.lateral = $urandom();
    m.turn = 16'($urandom());
    case ($urandom_range(0, 3))
      0: begin
        m.forward = $signed(m.forward) >>> 12;
        m.lateral = $signed(m.lateral) >>> 12;
      end
      1: m.turn = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      default: ;
    endcase
    return m;
  endfunction

  task automatic test_directed_extremes();
    move_t m;
    logic [31:0] ext [0:4];
    ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF};
    foreach (ext[i]) begin
      m = '{turn: 16'h0, lateral: ext[(i + 2) % 5], forward: ext[i]};
      send_move(m);
    end
    // heading wrap and quadrant edges
    for (int k = 0; k < 8; k++) begin
      m = '{turn: 16'((k[0] ? 16'h7FFF : 16'h8000) + k), lateral: 32'h0,
            forward: 32'h10000};
      send_move(m);
    end
    send_move('{turn: 16'h4000, lateral: 32'h7FFF_FFFF, forward: 32'h7FFF_FFFF});
    send_move('{turn: 16'h4000, lateral: 32'h7FFF_FFFF, forward: 32'h7FFF_FFFF});
    wait_idle();
  endtask

  task automatic test_scale_settings();
    logic [15:0] sv [0:3];
    sv = '{16'd1, 16'hFFFF, 16'd256, 16'd3};
    foreach (sv[i]) begin
      write_reg(ptd_pkg::REG_SCALE_X, {16'd0, sv[i]});
      write_reg(ptd_pkg::REG_SCALE_Y, {16'd0, sv[3 - i]});
      for (int k = 0; k < 4; k++) send_move(rand_move());
      wait_idle();
    end
    // zero scale acts as 1 in divisions
    write_reg(ptd_pkg::REG_SCALE_X, 32'h0);
    write_reg(ptd_pkg::REG_SCALE_Y, 32'h0);
    for (int k = 0; k < 3; k++) send_move(rand_move());
    wait_idle();
    write_reg(ptd_pkg::REG_SCALE_X, 32'd256);
    write_reg(ptd_pkg::REG_SCALE_Y, 32'd256);
  endtask

  task automatic test_init_writes();
    write_reg(ptd_pkg::REG_INIT_X, 32'h7FFF_FFFF);
    write_reg(ptd_pkg::REG_INIT_Y, 32'h8000_0000);
    write_reg(ptd_pkg::REG_INIT_HEADING, 32'hFFFF);
    for (int k = 0; k < 4; k++) send_move(rand_move());
    wait_idle();
    write_reg(ptd_pkg::REG_INIT_X, 32'h8000_0000);
    write_reg(ptd_pkg::REG_INIT_Y, 32'h7FFF_FFFF);
    write_reg(ptd_pkg::REG_INIT_HEADING, 32'h4000);
    for (int k = 0; k < 4; k++) send_move(rand_move());
    wait_idle();
    // unknown register index: no effect
    write_reg(3'd7, 32'hDEAD_BEEF);
    write_reg(3'd5, 32'h1234_5678);
    send_move(rand_move());
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 5; k++) send_move(rand_move());
    join
    wait_idle();
  endtask

  task automatic test_random_moves();
    for (int k = 0; k < 600; k++) begin
      if (k % 150 == 0) gap_max = $urandom_range(0, 1) ? 0 : 400;
      if (k % 200 == 199) begin
        wait_idle();
        write_reg(ptd_pkg::REG_SCALE_X, $urandom_range(1, 65535));
        write_reg(ptd_pkg::REG_SCALE_Y, $urandom_range(1, 65535));
        write_reg(ptd_pkg::REG_INIT_X, $urandom());
        write_reg(ptd_pkg::REG_INIT_Y, $urandom());
        write_reg(ptd_pkg::REG_INIT_HEADING, $urandom());
      end
      send_move(rand_move());
    end
    wait_idle();
  endtask

  initial begin
    px = 0; py = 0; hdg = 0; sc_x = 256; sc_y = 256;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(negedge clk_i);
    test_directed_extremes();
    test_scale_settings();
    test_init_writes();
    test_backpressure();
    test_random_moves();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
